FILE: hdl/bdps_pkg.sv
// Shared types and constants for the button debounce and page select unit.
`timescale 1ns / 1ps
`default_nettype none

package bdps_pkg;

	// Tracked buttons; only the first three have a pin
	localparam int BUTTONS   = 3;
	localparam int PIN_COUNT = 3;
	localparam int LANES     = (BUTTONS > PIN_COUNT) ? PIN_COUNT : BUTTONS;

	// Field widths
	localparam int AGE_W     = 24;
	localparam int ELAPSED_W = 16;
	localparam int PAGE_W    = 4;

	// Register port geometry
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int REG_SEL_W = 2;

	// Register index codes
	localparam logic [REG_SEL_W-1:0] REG_LOCKOUT    = 2'd0;
	localparam logic [REG_SEL_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [REG_SEL_W-1:0] REG_COMBO      = 2'd2;
	localparam logic [REG_SEL_W-1:0] REG_LAST_PAGE  = 2'd3;

	// Register reset values
	localparam logic [AGE_W-1:0]  LOCKOUT_RST    = 24'd50000;
	localparam logic [AGE_W-1:0]  LONG_PRESS_RST = 24'd1000000;
	localparam logic [AGE_W-1:0]  COMBO_RST      = 24'd5000000;
	localparam logic [PAGE_W-1:0] LAST_PAGE_RST  = 4'd3;

	// Button slots
	localparam int IDX_LEFT    = 0;
	localparam int IDX_RIGHT   = 1;
	localparam int IDX_CONFIRM = 2;

	// Timing configuration seen by the datapath
	typedef struct packed {
		logic [AGE_W-1:0]  lockout;
		logic [AGE_W-1:0]  long_press;
		logic [AGE_W-1:0]  combo;
		logic [PAGE_W-1:0] last_page;
	} cfg_t;

	// Per-button status after the current poll
	typedef struct packed {
		logic press;     // accepted falling edge
		logic held;      // low past long-press time
		logic level;     // accepted level
		logic combo_ok;  // age past combo time
	} lane_t;

	// Page stepping decision
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              changed;
		logic              step_down;
		logic              step_up;
		logic              boot;
	} page_t;

endpackage

`default_nettype wire

FILE: hdl/button_debounce_page_select_unit.sv
// Top level: button debounce, long-press page select and bootloader combo.
`timescale 1ns / 1ps
`default_nettype none

// One word goes in per poll and one result word comes out per poll. A word
// is registered at the input, evaluated against the per-button age counters
// and the page register, and its result lands in an output register;
// throughput is one word per clock unless the output stalls. The input
// register refills while a result waits, so the unit only stalls its input
// when both registers are full and out_ready is low. Configuration registers
// sit at byte addresses 0, 4, 8 and 12; the user must write them only while
// no word is in flight, which is not enforced; writes apply to the next word.
module button_debounce_page_select_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                raw_left,
	input  wire logic                                raw_right,
	input  wire logic                                raw_confirm,
	input  wire logic [bdps_pkg::ELAPSED_W-1:0]      elapsed_us,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     press_left,
	output logic                                     press_right,
	output logic                                     press_confirm,
	output logic                                     held_left,
	output logic                                     held_right,
	output logic                                     held_confirm,
	output logic      [bdps_pkg::PAGE_W-1:0]         page_index,
	output logic                                     page_changed,
	output logic                                     boot_request,
	// configuration
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [bdps_pkg::ADDR_W-1:0]         paddr,
	input  wire logic [bdps_pkg::DATA_W-1:0]         pwdata,
	output logic      [bdps_pkg::DATA_W-1:0]         prdata,
	output logic                                     pready
);

	bdps_pkg::cfg_t                            cfg;
	bdps_pkg::lane_t [bdps_pkg::PIN_COUNT-1:0] lane_st;
	bdps_pkg::page_t                           pg;
	logic [bdps_pkg::PIN_COUNT-1:0]            restart;

	// input register
	logic                                      valid_s1;
	logic [bdps_pkg::PIN_COUNT-1:0]            lvl_s1;
	logic [bdps_pkg::ELAPSED_W-1:0]            elapsed_s1;

	// result register
	logic                                      valid_s2;
	logic [bdps_pkg::PIN_COUNT-1:0]            press_s2;
	logic [bdps_pkg::PIN_COUNT-1:0]            held_s2;
	logic [bdps_pkg::PAGE_W-1:0]               page_s2;
	logic                                      changed_s2;
	logic                                      boot_s2;

	logic                                      adv;
	logic                                      load;

	// Handshake: evaluate when the result register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign load     = in_valid && in_ready;

	bdps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lvl_s1     <= {raw_confirm, raw_right, raw_left};
			elapsed_s1 <= elapsed_us;
		end
	end

	// Page steps restart the stepping button's age
	always_comb begin
		restart                        = '0;
		restart[bdps_pkg::IDX_LEFT]    = pg.step_down;
		restart[bdps_pkg::IDX_RIGHT]   = pg.step_up;
	end

	// Button lanes; absent buttons read released
	for (genvar g = 0; g < bdps_pkg::PIN_COUNT; g++) begin : g_lane
		if (g < bdps_pkg::LANES) begin : g_on
			bdps_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.level   (lvl_s1[g]),
				.elapsed (elapsed_s1),
				.cfg     (cfg),
				.restart (restart[g]),
				.st      (lane_st[g])
			);
		end else begin : g_off
			assign lane_st[g] = '{press: 1'b0, held: 1'b0, level: 1'b1, combo_ok: 1'b0};
		end
	end

	bdps_page u_page (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.left      (lane_st[bdps_pkg::IDX_LEFT]),
		.right     (lane_st[bdps_pkg::IDX_RIGHT]),
		.last_page (cfg.last_page),
		.pg        (pg)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < bdps_pkg::PIN_COUNT; i++) begin
				press_s2[i] <= lane_st[i].press;
				held_s2[i]  <= lane_st[i].held;
			end
			page_s2    <= pg.page;
			changed_s2 <= pg.changed;
			boot_s2    <= pg.boot;
		end
	end

	assign out_valid     = valid_s2;
	assign press_left    = press_s2[bdps_pkg::IDX_LEFT];
	assign press_right   = press_s2[bdps_pkg::IDX_RIGHT];
	assign press_confirm = press_s2[bdps_pkg::IDX_CONFIRM];
	assign held_left     = held_s2[bdps_pkg::IDX_LEFT];
	assign held_right    = held_s2[bdps_pkg::IDX_RIGHT];
	assign held_confirm  = held_s2[bdps_pkg::IDX_CONFIRM];
	assign page_index    = page_s2;
	assign page_changed  = changed_s2;
	assign boot_request  = boot_s2;

	// A page step needs a held left or right button
	a_step_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && page_changed |-> held_left || held_right)
		else $error("page step without a held button");

	// A press restarts the age, so the same word cannot report held
	a_press_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && press_left |-> !held_left)
		else $error("left press and held in one word");

	// Input stalls only with a full input register behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without backpressure");

	// A stalled result word is not overwritten
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(page_index)
			&& $stable(page_changed))
		else $error("result word changed under stall");

endmodule

`default_nettype wire

FILE: hdl/bdps_regs.sv
// Configuration register file with APB-style access.
`timescale 1ns / 1ps
`default_nettype none

module bdps_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [bdps_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [bdps_pkg::DATA_W-1:0]    pwdata,
	output logic      [bdps_pkg::DATA_W-1:0]    prdata,
	output logic                                pready,
	output bdps_pkg::cfg_t                      cfg
);

	bdps_pkg::cfg_t                        cfg_q;
	logic                                  wr_en;
	logic [bdps_pkg::REG_SEL_W-1:0]        sel;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign sel    = paddr[bdps_pkg::ADDR_W-1:2];
	assign cfg    = cfg_q;

	// Register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout    <= bdps_pkg::LOCKOUT_RST;
			cfg_q.long_press <= bdps_pkg::LONG_PRESS_RST;
			cfg_q.combo      <= bdps_pkg::COMBO_RST;
			cfg_q.last_page  <= bdps_pkg::LAST_PAGE_RST;
		end else if (wr_en) begin
			case (sel)
				bdps_pkg::REG_LOCKOUT:    cfg_q.lockout    <= pwdata[bdps_pkg::AGE_W-1:0];
				bdps_pkg::REG_LONG_PRESS: cfg_q.long_press <= pwdata[bdps_pkg::AGE_W-1:0];
				bdps_pkg::REG_COMBO:      cfg_q.combo      <= pwdata[bdps_pkg::AGE_W-1:0];
				bdps_pkg::REG_LAST_PAGE:  cfg_q.last_page  <= pwdata[bdps_pkg::PAGE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (sel)
			bdps_pkg::REG_LOCKOUT:    prdata[bdps_pkg::AGE_W-1:0]  = cfg_q.lockout;
			bdps_pkg::REG_LONG_PRESS: prdata[bdps_pkg::AGE_W-1:0]  = cfg_q.long_press;
			bdps_pkg::REG_COMBO:      prdata[bdps_pkg::AGE_W-1:0]  = cfg_q.combo;
			bdps_pkg::REG_LAST_PAGE:  prdata[bdps_pkg::PAGE_W-1:0] = cfg_q.last_page;
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/bdps_lane.sv
// One button lane: debounce with lockout, saturating age and long-press detect.
`timescale 1ns / 1ps
`default_nettype none

module bdps_lane (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  wire logic                              level,
	input  wire logic [bdps_pkg::ELAPSED_W-1:0]    elapsed,
	input  wire bdps_pkg::cfg_t                    cfg,
	input  wire logic                              restart,
	output bdps_pkg::lane_t                        st
);

	logic                           stable_q;
	logic [bdps_pkg::AGE_W-1:0]     age_q;
	logic [bdps_pkg::AGE_W:0]       sum;
	logic [bdps_pkg::AGE_W-1:0]     age_sat;
	logic [bdps_pkg::AGE_W-1:0]     age_n;
	logic                           take;

	// Age plus elapsed time, saturating
	assign sum     = {1'b0, age_q}
		+ {{(bdps_pkg::AGE_W + 1 - bdps_pkg::ELAPSED_W){1'b0}}, elapsed};
	assign age_sat = sum[bdps_pkg::AGE_W] ? '1 : sum[bdps_pkg::AGE_W-1:0];

	// Edge accepted only past lockout
	assign take  = (level != stable_q) && (age_sat > cfg.lockout);
	assign age_n = take ? '0 : age_sat;

	always_comb begin
		st.press    = take & ~level;
		st.held     = ~level & (age_n > cfg.long_press);
		st.level    = level;
		st.combo_ok = age_n > cfg.combo;
	end

	// Lane state; the level is taken over even inside lockout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b1;
			age_q    <= '0;
		end else if (adv) begin
			stable_q <= level;
			age_q    <= restart ? '0 : age_n;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/bdps_page.sv
// Page index register, stepping by long press, and the bootloader combo.
`timescale 1ns / 1ps
`default_nettype none

module bdps_page (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            adv,
	input  wire bdps_pkg::lane_t                 left,
	input  wire bdps_pkg::lane_t                 right,
	input  wire logic [bdps_pkg::PAGE_W-1:0]     last_page,
	output bdps_pkg::page_t                      pg
);

	logic [bdps_pkg::PAGE_W-1:0] page_q;
	logic                        down;
	logic                        up;

	// Left wins when both could step
	assign down = (page_q != '0) && left.held && right.level;
	assign up   = !down && (page_q < last_page) && right.held && left.level;

	always_comb begin
		pg.step_down = down;
		pg.step_up   = up;
		pg.changed   = down | up;
		pg.boot      = !left.level && !right.level && left.combo_ok && right.combo_ok;
		if (down) begin
			pg.page = page_q - 1'b1;
		end else if (up) begin
			pg.page = page_q + 1'b1;
		end else begin
			pg.page = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
		end else if (adv) begin
			page_q <= pg.page;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_button_debounce_page_select_unit.sv
// Self-checking testbench for the button debounce and page select unit.
`timescale 1ns / 1ps
`default_nettype none

module tb_button_debounce_page_select_unit;
	import bdps_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PRINT_CAP    = 100;

	localparam logic [AGE_W-1:0]     AGE_SAT     = '1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	// One poll word as driven on the input channel
	typedef struct packed {
		logic                 raw_left;
		logic                 raw_right;
		logic                 raw_confirm;
		logic [ELAPSED_W-1:0] elapsed;
	} poll_t;

	// One result word as seen on the output channel
	typedef struct packed {
		logic              press_left;
		logic              press_right;
		logic              press_confirm;
		logic              held_left;
		logic              held_right;
		logic              held_confirm;
		logic [PAGE_W-1:0] page_index;
		logic              page_changed;
		logic              boot_request;
	} outcome_t;

	// DUT signals, all inputs known from time zero
	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic                 raw_left    = 1'b1;
	logic                 raw_right   = 1'b1;
	logic                 raw_confirm = 1'b1;
	logic [ELAPSED_W-1:0] elapsed_us  = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic                 press_left;
	logic                 press_right;
	logic                 press_confirm;
	logic                 held_left;
	logic                 held_right;
	logic                 held_confirm;
	logic [PAGE_W-1:0]    page_index;
	logic                 page_changed;
	logic                 boot_request;
	logic                 psel        = 1'b0;
	logic                 penable     = 1'b0;
	logic                 pwrite      = 1'b0;
	logic [ADDR_W-1:0]    paddr       = '0;
	logic [DATA_W-1:0]    pwdata      = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	// Predictor state: timing registers, per-button level and age, page
	cfg_t              timing;
	logic              btn_level [BUTTONS];
	logic [AGE_W-1:0]  btn_age   [BUTTONS];
	logic [PAGE_W-1:0] page_sel;

	outcome_t results_due [$];
	int       error_count        = 0;
	int       sender_idle_pct    = 0;
	int       receiver_stall_pct = 0;

	button_debounce_page_select_unit uut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Debounce, long-press and page step for one poll; updates predictor state
	function automatic outcome_t advance_buttons(input poll_t p);
		logic [BUTTONS-1:0] pin;
		logic [BUTTONS-1:0] press;
		logic [BUTTONS-1:0] held;
		logic [AGE_W:0]     sum;
		logic [AGE_W-1:0]   age;
		outcome_t           r;
		pin   = '1;
		pin[IDX_LEFT]    = p.raw_left;
		pin[IDX_RIGHT]   = p.raw_right;
		pin[IDX_CONFIRM] = p.raw_confirm;
		press = '0;
		held  = '0;
		r     = '0;
		for (int b = 0; b < BUTTONS; b++) begin
			sum = {1'b0, btn_age[b]} + (AGE_W + 1)'(p.elapsed);
			age = sum[AGE_W] ? AGE_SAT : sum[AGE_W-1:0];
			// level is always taken over; edge counts only past lockout
			if (pin[b] != btn_level[b] && age > timing.lockout) begin
				press[b] = !pin[b] && btn_level[b];
				age      = '0;
			end
			btn_level[b] = pin[b];
			btn_age[b]   = age;
			held[b]      = !pin[b] && age > timing.long_press;
		end
		r.boot_request = !btn_level[IDX_LEFT] && !btn_level[IDX_RIGHT] &&
			btn_age[IDX_LEFT] > timing.combo && btn_age[IDX_RIGHT] > timing.combo;
		// left wins when both could step
		if (page_sel > 0 && held[IDX_LEFT] && btn_level[IDX_RIGHT]) begin
			page_sel           = page_sel - 1'b1;
			r.page_changed     = 1'b1;
			btn_age[IDX_LEFT]  = '0;
		end else if (page_sel < timing.last_page && held[IDX_RIGHT] &&
				btn_level[IDX_LEFT]) begin
			page_sel           = page_sel + 1'b1;
			r.page_changed     = 1'b1;
			btn_age[IDX_RIGHT] = '0;
		end
		r.press_left    = press[IDX_LEFT];
		r.press_right   = press[IDX_RIGHT];
		r.press_confirm = press[IDX_CONFIRM];
		r.held_left     = held[IDX_LEFT];
		r.held_right    = held[IDX_RIGHT];
		r.held_confirm  = held[IDX_CONFIRM];
		r.page_index    = page_sel;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Send one poll word; entered and left at a falling edge
	task automatic send_poll(input poll_t p);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		raw_left    <= p.raw_left;
		raw_right   <= p.raw_right;
		raw_confirm <= p.raw_confirm;
		elapsed_us  <= p.elapsed;
		do @(posedge clk); while (!in_ready);
		results_due.push_back(advance_buttons(p));
		@(negedge clk);
	endtask

	task automatic send_levels(input logic l, input logic r, input logic c,
			input logic [ELAPSED_W-1:0] e);
		poll_t p;
		p.raw_left    = l;
		p.raw_right   = r;
		p.raw_confirm = c;
		p.elapsed     = e;
		send_poll(p);
	endtask

	// Stop sending and wait until every result word is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic read_register_check(input logic [REG_SEL_W-1:0] idx);
		logic [DATA_W-1:0] want;
		case (idx)
			REG_LOCKOUT:    want = DATA_W'(timing.lockout);
			REG_LONG_PRESS: want = DATA_W'(timing.long_press);
			REG_COMBO:      want = DATA_W'(timing.combo);
			default:        want = DATA_W'(timing.last_page);
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field($sformatf("register %0d readback", idx), prdata, want);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Model update, APB write, then read back
	task automatic write_register(input logic [REG_SEL_W-1:0] idx,
			input logic [AGE_W-1:0] value);
		logic [DATA_W-1:0] data;
		case (idx)
			REG_LOCKOUT:    timing.lockout    = value;
			REG_LONG_PRESS: timing.long_press = value;
			REG_COMBO:      timing.combo      = value;
			default:        timing.last_page  = value[PAGE_W-1:0];
		endcase
		data = (idx == REG_LAST_PAGE) ? DATA_W'(value[PAGE_W-1:0]) : DATA_W'(value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		read_register_check(idx);
	endtask

	task automatic set_timing(input logic [AGE_W-1:0] lockout,
			input logic [AGE_W-1:0] long_press, input logic [AGE_W-1:0] combo,
			input logic [PAGE_W-1:0] last_page);
		drain_results();
		write_register(REG_LOCKOUT, lockout);
		write_register(REG_LONG_PRESS, long_press);
		write_register(REG_COMBO, combo);
		write_register(REG_LAST_PAGE, AGE_W'(last_page));
	endtask

	// Reset values of all registers
	task automatic test_register_reset_values();
		read_register_check(REG_LOCKOUT);
		read_register_check(REG_LONG_PRESS);
		read_register_check(REG_COMBO);
		read_register_check(REG_LAST_PAGE);
	endtask

	// Lockout boundaries, zero times, page limits, combo and both-held priority
	task automatic test_directed_polls();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		send_levels(1, 1, 1, '0);
		send_levels(0, 1, 1, '0);          // change inside lockout
		send_levels(1, 1, 1, ELAPSED_MAX); // rising edge accepted
		send_levels(0, 1, 1, 16'd50000);   // age equal to lockout: rejected
		send_levels(1, 1, 1, 16'd1);
		send_levels(0, 1, 1, 16'd50001);   // press
		set_timing('0, '0, '0, 4'd15);
		send_levels(1, 0, 1, 16'd1);
		send_levels(1, 0, 1, 16'd1);       // right held: step up
		send_levels(1, 0, 1, '0);          // zero age never held
		send_levels(1, 0, 1, ELAPSED_MAX);
		send_levels(1, 0, 1, 16'd7);
		set_timing('0, '0, '0, '0);        // last page below current page
		send_levels(1, 0, 1, 16'd5);
		send_levels(0, 1, 1, 16'd5);
		send_levels(0, 1, 1, 16'd5);       // step down still allowed
		send_levels(0, 0, 0, 16'd9);
		send_levels(0, 0, 0, 16'd3);       // both held: combo, no step
		send_levels(0, 0, 0, ELAPSED_MAX);
		send_levels(1, 1, 1, '0);
		send_levels(0, 1, 0, '0);          // zero lockout with zero age
	endtask

	// Age counters run into saturation with every button low
	task automatic test_age_saturation();
		set_timing(AGE_SAT, AGE_SAT - 1'b1, AGE_SAT - 1'b1, 4'd15);
		sender_idle_pct    = 33;
		receiver_stall_pct = 33;
		repeat (260) send_levels(0, 0, 0, ELAPSED_MAX);
		set_timing(AGE_SAT, AGE_SAT - 1'b1, AGE_SAT, 4'd15);
		repeat (3) send_levels(0, 0, 0, ELAPSED_MAX);
		repeat (2) send_levels(1, 1, 1, ELAPSED_MAX);
	endtask

	// Bounced press-and-hold gestures with some raw noise
	task automatic test_random_polls(input int idle_pct, input int stall_pct,
			input int count, input int scale);
		int       sent;
		int       pick;
		int       hold;
		int       bounces;
		logic [2:0] target;
		logic [2:0] lv;
		logic [ELAPSED_W-1:0] e;
		set_timing(AGE_W'($urandom_range(0, 2 * scale)),
			AGE_W'($urandom_range(scale, 20 * scale)),
			AGE_W'($urandom_range(5 * scale, 40 * scale)),
			PAGE_W'($urandom_range(0, 15)));
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 2)
				drain_results();
			if (pick < 15) begin
				// raw noise word
				lv = 3'($urandom);
				case ($urandom_range(0, 3))
					0:       e = '0;
					1:       e = ELAPSED_MAX;
					default: e = ELAPSED_W'($urandom_range(0, 65535));
				endcase
				send_levels(lv[0], lv[1], lv[2], e);
				sent++;
			end else begin
				// {confirm, right, left}, low = pressed
				case ($urandom_range(0, 9))
					0, 1:    target = 3'b111;
					2, 3:    target = 3'b110;
					4, 5:    target = 3'b101;
					6:       target = 3'b011;
					7, 8:    target = 3'b100;
					default: target = 3'($urandom);
				endcase
				bounces = $urandom_range(0, 3);
				for (int k = 0; k < bounces && sent < count; k++) begin
					lv = target ^ 3'($urandom);
					send_levels(lv[0], lv[1], lv[2],
						ELAPSED_W'($urandom_range(0, scale / 8)));
					sent++;
				end
				hold = $urandom_range(1, (target[1:0] == 2'b00) ? 80 : 30);
				for (int k = 0; k < hold && sent < count; k++) begin
					send_levels(target[0], target[1], target[2],
						ELAPSED_W'($urandom_range(0, scale)));
					sent++;
				end
			end
		end
	endtask

	// Random receiver stalls
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				report_mismatch("result word with none expected");
			end else begin
				want = results_due.pop_front();
				check_field("press_left", 32'(press_left), 32'(want.press_left));
				check_field("press_right", 32'(press_right), 32'(want.press_right));
				check_field("press_confirm", 32'(press_confirm),
					32'(want.press_confirm));
				check_field("held_left", 32'(held_left), 32'(want.held_left));
				check_field("held_right", 32'(held_right), 32'(want.held_right));
				check_field("held_confirm", 32'(held_confirm),
					32'(want.held_confirm));
				check_field("page_index", 32'(page_index), 32'(want.page_index));
				check_field("page_changed", 32'(page_changed),
					32'(want.page_changed));
				check_field("boot_request", 32'(boot_request),
					32'(want.boot_request));
			end
		end
	end

	initial begin
		timing.lockout    = LOCKOUT_RST;
		timing.long_press = LONG_PRESS_RST;
		timing.combo      = COMBO_RST;
		timing.last_page  = LAST_PAGE_RST;
		for (int b = 0; b < BUTTONS; b++) begin
			btn_level[b] = 1'b1;
			btn_age[b]   = '0;
		end
		page_sel = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_register_reset_values();
		test_directed_polls();
		test_age_saturation();
		test_random_polls(0, 0, 230, 2000);
		test_random_polls(60, 0, 230, 2000);
		test_random_polls(0, 60, 230, 65535);
		test_random_polls(33, 33, 230, 600);
		drain_results();
		if (error_count == 0)
			$display("tb_button_debounce_page_select_unit OK");
		else
			$display("tb_button_debounce_page_select_unit NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("tb_button_debounce_page_select_unit NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
hdl/bdps_pkg.sv
hdl/bdps_regs.sv
hdl/bdps_lane.sv
hdl/bdps_page.sv
hdl/button_debounce_page_select_unit.sv
tb/sv/tb_button_debounce_page_select_unit.sv
